[hw/rtl/deq_pkg.sv]
`timescale 1ns / 1ps

package deq_pkg;

	// Ring capacity and derived widths
	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OCC_W = 7;
	localparam int WORD_W = 32;

	// Request codes
	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// What a chain of cells does in one cycle
	typedef enum logic [1:0] {
		CH_HOLD       = 2'd0,
		CH_SHIFT_IN   = 2'd1,
		CH_SHIFT_OUT  = 2'd2,
		CH_TAIL_WRITE = 2'd3
	} chain_op_t;

	localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

	typedef struct packed {
		op_t                      operation;
		logic signed [WORD_W-1:0] push_value;
	} req_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] pop_value;
		status_t                  status;
		logic [OCC_W-1:0]         occupancy;
	} rsp_item_t;

	// Broadcast control for every cell of one chain
	typedef struct packed {
		chain_op_t                op;
		logic signed [WORD_W-1:0] word;
		logic [CNT_W-1:0]         count;
	} cell_ctrl_t;

endpackage

[hw/rtl/deq_cell.sv]
`timescale 1ns / 1ps

module deq_cell (
	input  logic                              clk,
	input  deq_pkg::cell_ctrl_t               ctrl,
	input  logic [deq_pkg::CNT_W-1:0]         index,
	input  logic signed [deq_pkg::WORD_W-1:0] left_data,
	input  logic signed [deq_pkg::WORD_W-1:0] right_data,
	output logic signed [deq_pkg::WORD_W-1:0] cell_data
);
	import deq_pkg::*;

	logic signed [WORD_W-1:0] data_q;

	// One word; moves toward the far end, toward the head, or takes the tail write
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CH_SHIFT_IN:   data_q <= left_data;
			CH_SHIFT_OUT:  data_q <= right_data;
			CH_TAIL_WRITE: begin
				if (index == ctrl.count) begin
					data_q <= ctrl.word;
				end
			end
			CH_HOLD:       data_q <= data_q;
		endcase
	end

	assign cell_data = data_q;

endmodule

[hw/rtl/deq_chain.sv]
`timescale 1ns / 1ps

module deq_chain (
	input  logic                              clk,
	input  deq_pkg::cell_ctrl_t               ctrl,
	output logic signed [deq_pkg::WORD_W-1:0] head
);
	import deq_pkg::*;

	logic signed [WORD_W-1:0] cell_data [DEPTH];

	// Row of cells; cell 0 is the head, where shifted-in words enter; a tail write lands in cell count
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WORD_W-1:0] left_in;
		logic signed [WORD_W-1:0] right_in;

		if (i == 0) begin : g_first
			assign left_in = ctrl.word;
		end else begin : g_mid
			assign left_in = cell_data[i-1];
		end

		// past the last cell nothing is stored
		if (i == DEPTH - 1) begin : g_last
			assign right_in = '0;
		end else begin : g_inner
			assign right_in = cell_data[i+1];
		end

		deq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.index      (CNT_W'(i)),
			.left_data  (left_in),
			.right_data (right_in),
			.cell_data  (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

[hw/rtl/double_ended_queue.sv]
`timescale 1ns / 1ps
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------
// req      | req_valid/req_ready  | req_item_t: operation, push_value
// rsp      | rsp_valid/rsp_ready  | rsp_item_t: pop_value, status, occupancy
//
// One request per cycle while the result is taken; its result is registered and shows in the next cycle.
// Two rows of cells hold the words, one with the front word in cell 0 and
// one with the back word in cell 0, so every pop reads a fixed cell.
// Reset clears the count and the result valid; cell contents are left as is.
// A stalled result holds req_ready low only while rsp_ready is low.

module double_ended_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  deq_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output deq_pkg::rsp_item_t rsp
);
	import deq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;
	rsp_item_t        rsp_next;
	cell_ctrl_t       front_ctrl;
	cell_ctrl_t       back_ctrl;
	logic signed [WORD_W-1:0] front_head;
	logic signed [WORD_W-1:0] back_head;
	logic             accept;
	logic             full;
	logic             empty;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	// Decode request into chain moves, new count and result
	always_comb begin
		front_ctrl.op    = CH_HOLD;
		front_ctrl.word  = req.push_value;
		front_ctrl.count = count_q;
		back_ctrl.op     = CH_HOLD;
		back_ctrl.word   = req.push_value;
		back_ctrl.count  = count_q;
		count_next       = count_q;
		rsp_next.pop_value = '0;
		rsp_next.status    = ST_DONE;

		unique case (req.operation)
			OP_PUSH_FRONT: begin
				if (full) begin
					rsp_next.status = ST_FULL;
				end else begin
					front_ctrl.op = CH_SHIFT_IN;
					back_ctrl.op  = CH_TAIL_WRITE;
					count_next    = count_q + CNT_W'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					rsp_next.status = ST_FULL;
				end else begin
					back_ctrl.op  = CH_SHIFT_IN;
					front_ctrl.op = CH_TAIL_WRITE;
					count_next    = count_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					rsp_next.pop_value = EMPTY_WORD;
					rsp_next.status    = ST_EMPTY;
				end else begin
					front_ctrl.op      = CH_SHIFT_OUT;
					rsp_next.pop_value = front_head;
					count_next         = count_q - CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					rsp_next.pop_value = EMPTY_WORD;
					rsp_next.status    = ST_EMPTY;
				end else begin
					back_ctrl.op       = CH_SHIFT_OUT;
					rsp_next.pop_value = back_head;
					count_next         = count_q - CNT_W'(1);
				end
			end
		endcase

		// chains move only on an accepted item
		if (!accept) begin
			front_ctrl.op = CH_HOLD;
			back_ctrl.op  = CH_HOLD;
		end

		rsp_next.occupancy = OCC_W'(count_next);
	end

	deq_chain u_front (
		.clk  (clk),
		.ctrl (front_ctrl),
		.head (front_head)
	);

	deq_chain u_back (
		.clk  (clk),
		.ctrl (back_ctrl),
		.head (back_head)
	);

	// Count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[test/double_ended_queue_test.sv]
`timescale 1ns / 1ps

module double_ended_queue_test;
	import deq_pkg::*;

	localparam int ITEM_TARGET = 1450;
	localparam int CALM_TAIL = 150;
	localparam int LONG_HOLD_AT = 200;
	localparam int LONG_HOLD_CYCLES = 400;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	double_ended_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Stimulus and expected results
	req_item_t queued_requests[$];
	rsp_item_t pending_results[$];
	int        total_items = 0;
	int        accepted_reqs = 0;
	int        checked_rsps = 0;
	int        mismatches = 0;

	// Predicted deque contents
	logic signed [WORD_W-1:0] ring_words[DEPTH];
	int                       front_pos = 0;
	int                       fill_level = 0;
	int                       full_refusals = 0;
	int                       empty_pops = 0;
	int                       peak_fill = 0;

	// Apply one request to the predicted deque and return its result
	function automatic rsp_item_t deque_apply(req_item_t r);
		rsp_item_t res;
		int        pos;
		res.pop_value = '0;
		res.status = ST_DONE;
		case (r.operation)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (fill_level >= DEPTH) begin
					res.status = ST_FULL;
					full_refusals++;
				end else begin
					if (r.operation == OP_PUSH_FRONT) begin
						front_pos = (front_pos + DEPTH - 1) % DEPTH;
						pos = front_pos;
					end else begin
						pos = (front_pos + fill_level) % DEPTH;
					end
					ring_words[pos] = r.push_value;
					fill_level++;
				end
			end
			default: begin
				if (fill_level == 0) begin
					res.pop_value = EMPTY_WORD;
					res.status = ST_EMPTY;
					empty_pops++;
				end else begin
					if (r.operation == OP_POP_FRONT) begin
						pos = front_pos;
						front_pos = (front_pos + 1) % DEPTH;
					end else begin
						pos = (front_pos + fill_level - 1) % DEPTH;
					end
					res.pop_value = ring_words[pos];
					fill_level--;
				end
			end
		endcase
		if (fill_level > peak_fill)
			peak_fill = fill_level;
		res.occupancy = OCC_W'(fill_level);
		return res;
	endfunction

	function automatic req_item_t make_req(op_t op, logic signed [WORD_W-1:0] v);
		req_item_t r;
		r.operation = op;
		r.push_value = v;
		return r;
	endfunction

	// Random word, leaning on the extremes now and then
	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return -32'sd1;
			3: return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	task automatic note_mismatch(string msg);
		if (mismatches < 10)
			$display("%s", msg);
		mismatches++;
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: offer queued requests, with idle bursts outside the calm stretches
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			gap_left <= 0;
		end else begin
			if (req_valid && req_ready) begin
				pending_results.push_back(deque_apply(req));
				accepted_reqs++;
			end
			if (!req_valid || req_ready) begin
				if (gap_left > 0) begin
					req_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (queued_requests.size() == 0) begin
					req_valid <= 1'b0;
				end else if (total_items - accepted_reqs > CALM_TAIL &&
						accepted_reqs % 300 < 200 && $urandom_range(0, 5) == 0) begin
					req_valid <= 1'b0;
					gap_left <= $urandom_range(0, 14);
				end else begin
					req_valid <= 1'b1;
					req <= queued_requests.pop_front();
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold to back the block up
	int drained = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			drained <= 0;
			stall_left <= 0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready)
				drained <= drained + 1;
			if (!long_hold_done && drained >= LONG_HOLD_AT) begin
				long_hold_done <= 1'b1;
				hold_left <= LONG_HOLD_CYCLES;
				rsp_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp_ready <= 1'b0;
			end else if (total_items - drained > CALM_TAIL && drained % 256 < 170 &&
					$urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 14);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Monitor: compare every result with the oldest prediction
	rsp_item_t want;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			checked_rsps++;
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result: pop_value %0d status %0d occ %0d",
					rsp.pop_value, rsp.status, rsp.occupancy));
			end else begin
				want = pending_results.pop_front();
				if (rsp.pop_value !== want.pop_value || rsp.status !== want.status ||
						rsp.occupancy !== want.occupancy)
					note_mismatch($sformatf(
						"result %0d: expected pop_value %0d status %0d occ %0d, got %0d %0d %0d",
						checked_rsps, want.pop_value, want.status, want.occupancy,
						rsp.pop_value, rsp.status, rsp.occupancy));
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int   kind;
		int   len;
		op_t  op;

		// Directed: empty pops, extreme words at both ends, drain past empty
		queued_requests.push_back(make_req(OP_POP_FRONT, 32'sd0));
		queued_requests.push_back(make_req(OP_POP_BACK, 32'sh12345678));
		queued_requests.push_back(make_req(OP_PUSH_BACK, 32'sh7fffffff));
		queued_requests.push_back(make_req(OP_PUSH_FRONT, 32'sh80000000));
		queued_requests.push_back(make_req(OP_PUSH_BACK, -32'sd1));
		queued_requests.push_back(make_req(OP_PUSH_FRONT, 32'sd0));
		queued_requests.push_back(make_req(OP_PUSH_BACK, 32'sh55555555));
		queued_requests.push_back(make_req(OP_PUSH_FRONT, 32'shaaaaaaaa));
		queued_requests.push_back(make_req(OP_POP_BACK, 32'shffffffff));
		queued_requests.push_back(make_req(OP_POP_FRONT, 32'sd0));
		queued_requests.push_back(make_req(OP_POP_FRONT, 32'sd0));
		queued_requests.push_back(make_req(OP_POP_BACK, 32'sd0));
		queued_requests.push_back(make_req(OP_POP_BACK, 32'sd0));
		queued_requests.push_back(make_req(OP_POP_FRONT, 32'sd0));
		queued_requests.push_back(make_req(OP_POP_FRONT, 32'sh7fffffff));
		queued_requests.push_back(make_req(OP_PUSH_FRONT, 32'sh00000001));
		queued_requests.push_back(make_req(OP_POP_BACK, 32'sd0));
		queued_requests.push_back(make_req(OP_PUSH_BACK, 32'sh80000001));
		queued_requests.push_back(make_req(OP_POP_FRONT, 32'sd0));
		queued_requests.push_back(make_req(OP_POP_BACK, 32'sh80000000));

		// Fill past full from random ends, then drain past empty
		for (int i = 0; i < DEPTH + 6; i++)
			queued_requests.push_back(make_req(op_t'($urandom_range(0, 1)), pick_word()));
		for (int i = 0; i < DEPTH + 6; i++)
			queued_requests.push_back(make_req(op_t'($urandom_range(2, 3)), $urandom));

		// Random bursts: fills, drains, queue-like and stack-like mixes, noise
		while (queued_requests.size() < ITEM_TARGET) begin
			kind = $urandom_range(0, 4);
			len = $urandom_range(10, 80);
			for (int k = 0; k < len; k++) begin
				case (kind)
					0: op = op_t'($urandom_range(0, 1));
					1: op = op_t'($urandom_range(2, 3));
					2: op = ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_POP_FRONT;
					3: op = ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_POP_FRONT;
					default: op = op_t'($urandom_range(0, 3));
				endcase
				queued_requests.push_back(make_req(op, pick_word()));
			end
		end
		total_items = queued_requests.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_reqs < total_items || pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d requests, %0d results checked, peak fill %0d of %0d.",
			total_items, checked_rsps, peak_fill, DEPTH);
		$display("Saw %0d pushes refused on a full deque and %0d pops on an empty one.",
			full_refusals, empty_pops);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS double_ended_queue");
		else
			$display("FAIL double_ended_queue");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("FAIL double_ended_queue");
		$finish;
	end

endmodule
